// ===== rtl/zsew_pkg.sv =====
// zsew_pkg: constants, codes, channel payloads and a helper function for the stored-entry walker
// no dependencies
`default_nettype none
package zsew_pkg;
  localparam int POSITION_BITS_DEF = 32;
  localparam int COUNT_BITS_DEF = 16;
  localparam logic [31:0] SIG_LOCAL = 32'h04034b50;
  localparam logic [31:0] SIG_CENTRAL = 32'h02014b50;
  localparam logic [31:0] SIG_END = 32'h06054b50;

  localparam logic [1:0] CFG_MAX_ARCHIVE = 2'd0;
  localparam logic [1:0] CFG_MAX_ENTRY = 2'd1;
  localparam logic [1:0] CFG_MAX_COUNT = 2'd2;

  localparam logic [3:0] ST_OK = 4'd0;
  localparam logic [3:0] ST_SHORT = 4'd1;
  localparam logic [3:0] ST_TOO_BIG = 4'd2;
  localparam logic [3:0] ST_TRUNC = 4'd3;
  localparam logic [3:0] ST_COMPRESSED = 4'd4;
  localparam logic [3:0] ST_MISMATCH = 4'd5;
  localparam logic [3:0] ST_ENTRY_BIG = 4'd6;
  localparam logic [3:0] ST_UNSAFE = 4'd7;
  localparam logic [3:0] ST_TOO_MANY = 4'd8;
  localparam logic [3:0] ST_TRAILER = 4'd9;
  localparam logic [3:0] ST_NONE = 4'd10;

  typedef enum logic [2:0] {PH_HDR, PH_NAME, PH_EXTRA, PH_DATA, PH_STOP} phase_t;

  // channel payloads
  typedef struct packed {
    logic       has_byte;
    logic [7:0] archive_byte;
    logic       end_of_archive;
  } byte_item_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [31:0] data;
  } reg_write_t;

  typedef struct packed {
    logic        result_kind;
    logic [3:0]  status;
    logic [15:0] entry_index;
    logic [31:0] data_offset;
    logic [31:0] entry_size;
    logic        last_of_run;
  } walk_result_t;

  typedef struct packed {
    logic [1:0] esc;
    logic [3:0] esc_hi;
    logic [1:0] count;
    logic       first_letter;
    logic [1:0] seg;
    logic       bad;
  } name_state_t;

  typedef struct packed {
    logic       valid;
    logic       kind;
    logic [3:0] status;
    logic [15:0] index;
    logic [31:0] offset;
    logic [31:0] size;
    logic       last;
  } result_t;

  function automatic logic [4:0] hex_val(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b0, c[3:0]};
    if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
      return 5'(c[3:0] + 4'd9);
    return 5'd16;
  endfunction
endpackage
`default_nettype wire

// ===== rtl/zsew_stream_if.sv =====
// zsew_stream_if: valid/ready channel with a generic payload
// uses no package
`default_nettype none
interface zsew_stream_if #(parameter type payload_t = logic) (input wire logic clk);
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/zsew_name_check.sv =====
// zsew_name_check: next state of the entry name vetting for one raw byte
// depends on zsew_pkg
`default_nettype none
module zsew_name_check import zsew_pkg::*; (
  input  wire name_state_t cur,
  input  wire logic [7:0]  raw,
  output name_state_t      nxt
);
  logic [4:0] h;
  logic [7:0] c;
  logic       use_char;
  name_state_t s;
  always_comb begin
    h = hex_val(raw);
    s = cur;
    c = (raw == 8'h5c) ? 8'h2f : raw;
    use_char = 1'b0;
    if (!cur.bad) begin
      if (cur.esc == 2'd1) begin
        if (h[4]) s.bad = 1'b1;
        else begin
          s.esc_hi = h[3:0];
          s.esc = 2'd2;
        end
      end else if (cur.esc == 2'd2) begin
        if (h[4]) s.bad = 1'b1;
        else begin
          s.esc = 2'd0;
          c = {cur.esc_hi, h[3:0]};
          use_char = 1'b1;
        end
      end else if (c == 8'h25) s.esc = 2'd1;
      else use_char = 1'b1;
    end
    if (use_char) begin
      if (c == 8'h00) s.bad = 1'b1;
      if (cur.count == 2'd0) begin
        if (c == 8'h2f) s.bad = 1'b1;
        s.first_letter = (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a);
      end else if (cur.count == 2'd1 && cur.first_letter && c == 8'h3a) s.bad = 1'b1;
      if (c == 8'h2f) begin
        if (cur.seg != 2'd3) s.bad = 1'b1;
        s.seg = 2'd0;
      end else if (c == 8'h2e) begin
        if (cur.seg != 2'd3) s.seg = cur.seg + 2'd1;
      end else s.seg = 2'd3;
      if (cur.count != 2'd2) s.count = cur.count + 2'd1;
    end
    nxt = s;
  end
endmodule
`default_nettype wire

// ===== rtl/zsew_out_buf.sv =====
// zsew_out_buf: four-deep result queue feeding the output channel
// depends on zsew_pkg, zsew_stream_if
`default_nettype none
module zsew_out_buf import zsew_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire result_t  push_a,
  input  wire result_t  push_b,
  output logic          room,
  zsew_stream_if.source out
);
  result_t q [4];
  logic [2:0] cnt;
  logic [1:0] rd;
  logic [1:0] wr;
  logic pop;
  logic [2:0] cnt_next;
  assign pop = out.valid && out.ready;
  assign room = (cnt <= 3'd2);
  assign out.valid = (cnt != 3'd0);
  always_comb begin
    out.payload.result_kind = q[rd].kind;
    out.payload.status = q[rd].status;
    out.payload.entry_index = q[rd].index;
    out.payload.data_offset = q[rd].offset;
    out.payload.entry_size = q[rd].size;
    out.payload.last_of_run = q[rd].last;
  end
  always_comb begin
    cnt_next = cnt - {2'b0, pop} + {2'b0, push_a.valid} + {2'b0, push_b.valid};
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      rd <= '0;
      wr <= '0;
    end else begin
      cnt <= cnt_next;
      if (pop) rd <= rd + 2'd1;
      if (push_a.valid && push_b.valid) wr <= wr + 2'd2;
      else if (push_a.valid || push_b.valid) wr <= wr + 2'd1;
    end
    if (push_a.valid) q[wr] <= push_a;
    if (push_b.valid) q[push_a.valid ? wr + 2'd1 : wr] <= push_b;
  end
endmodule
`default_nettype wire

// ===== rtl/zsew_walker.sv =====
// zsew_walker: per-byte header, section, limit and status logic
// depends on zsew_pkg, zsew_name_check
`default_nettype none
module zsew_walker import zsew_pkg::*; #(
  parameter int POSITION_BITS = POSITION_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        step,
  input  wire logic        has_byte,
  input  wire logic [7:0]  archive_byte,
  input  wire logic        end_of_archive,
  input  wire logic [31:0] max_archive_bytes,
  input  wire logic [31:0] max_entry_bytes,
  input  wire logic [15:0] max_entry_count,
  output result_t          res_a,
  output result_t          res_b
);
  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  phase_t phase, phase_n;
  logic [4:0] hidx, hidx_n;
  logic [31:0] sig, sig_n, packed_size, packed_n, unpacked_size, unpacked_n, rem, rem_n;
  logic [15:0] comp, comp_n, name_len, name_len_n, extra_len, extra_len_n;
  logic [POSITION_BITS-1:0] pos, pos_n, dstart, dstart_n;
  logic [COUNT_BITS-1:0] seen, seen_n;
  logic ovf, ovf_n;
  name_state_t ns, ns_n, ns_byte;
  logic [3:0] err, err_n, code, fstat;
  logic done, rec;
  logic [4:0] hi1;
  result_t ra, rb;

  zsew_name_check u_name (.cur(ns), .raw(archive_byte), .nxt(ns_byte));

  always_comb begin
    phase_n = phase; hidx_n = hidx; sig_n = sig; comp_n = comp;
    packed_n = packed_size; unpacked_n = unpacked_size; name_len_n = name_len;
    extra_len_n = extra_len; rem_n = rem; pos_n = pos; dstart_n = dstart;
    seen_n = seen; ovf_n = ovf; ns_n = ns; err_n = err;
    done = 1'b0; rec = 1'b0; code = ST_OK; hi1 = hidx + 5'd1;
    ra = '0; rb = '0;
    if (has_byte) begin
      if (pos == POS_MAX) begin
        ovf_n = 1'b1;
        if (phase != PH_STOP) begin
          err_n = ST_TRUNC; phase_n = PH_STOP;
        end
      end else begin
        pos_n = pos + 1'b1;
        if (phase == PH_HDR) begin
          case (hidx)
            5'd0: sig_n[7:0] = archive_byte;
            5'd1: sig_n[15:8] = archive_byte;
            5'd2: sig_n[23:16] = archive_byte;
            5'd3: sig_n[31:24] = archive_byte;
            5'd8: comp_n[7:0] = archive_byte;
            5'd9: comp_n[15:8] = archive_byte;
            5'd18: packed_n[7:0] = archive_byte;
            5'd19: packed_n[15:8] = archive_byte;
            5'd20: packed_n[23:16] = archive_byte;
            5'd21: packed_n[31:24] = archive_byte;
            5'd22: unpacked_n[7:0] = archive_byte;
            5'd23: unpacked_n[15:8] = archive_byte;
            5'd24: unpacked_n[23:16] = archive_byte;
            5'd25: unpacked_n[31:24] = archive_byte;
            5'd26: name_len_n[7:0] = archive_byte;
            5'd27: name_len_n[15:8] = archive_byte;
            5'd28: extra_len_n[7:0] = archive_byte;
            5'd29: extra_len_n[15:8] = archive_byte;
            default: ;
          endcase
          hidx_n = hi1;
          if (hi1 == 5'd4 && sig_n != SIG_LOCAL) begin
            if (sig_n != SIG_CENTRAL && sig_n != SIG_END) err_n = ST_TRAILER;
            phase_n = PH_STOP;
          end else if (hi1 == 5'd30) begin
            // collapse empty sections straight through to data
            dstart_n = pos_n;
            if (name_len_n != 16'd0) begin
              phase_n = PH_NAME; rem_n = {16'd0, name_len_n};
            end else if (extra_len_n != 16'd0) begin
              phase_n = PH_EXTRA; rem_n = {16'd0, extra_len_n};
            end else begin
              phase_n = PH_DATA; rem_n = packed_n; done = (packed_n == 32'd0);
            end
          end
        end else if (phase != PH_STOP) begin
          if (phase == PH_NAME) ns_n = ns_byte;
          rem_n = rem - 32'd1;
          if (rem_n == 32'd0) begin
            if (phase == PH_NAME && extra_len != 16'd0) begin
              phase_n = PH_EXTRA; rem_n = {16'd0, extra_len};
            end else if (phase != PH_DATA && packed_size != 32'd0) begin
              // data starts at the next byte
              phase_n = PH_DATA; rem_n = packed_size; dstart_n = pos_n;
            end else begin
              if (phase != PH_DATA) dstart_n = pos_n;
              phase_n = PH_DATA; done = 1'b1;
            end
          end
        end
        if (done) begin
          if (comp_n != 16'd0) code = ST_COMPRESSED;
          else if (unpacked_n != packed_n) code = ST_MISMATCH;
          else if (max_entry_bytes != 32'd0 && unpacked_n > max_entry_bytes)
            code = ST_ENTRY_BIG;
          else if (ns_n.bad || ns_n.esc != 2'd0 || ns_n.count == 2'd0 || ns_n.seg != 2'd3)
            code = ST_UNSAFE;
          else if ((max_entry_count != 16'd0 &&
                    {{32{1'b0}}, seen} >= {{COUNT_BITS{1'b0}}, 16'd0, max_entry_count})
                   || seen == COUNT_MAX)
            code = ST_TOO_MANY;
          if (code != ST_OK) begin
            err_n = code; phase_n = PH_STOP;
          end else begin
            rec = 1'b1;
            ra.valid = 1'b1;
            ra.index = 16'(seen);
            ra.offset = 32'(dstart_n);
            ra.size = packed_n;
            ra.last = !end_of_archive;
            seen_n = seen + 1'b1;
            phase_n = PH_HDR; hidx_n = '0; sig_n = '0; comp_n = '0; packed_n = '0;
            unpacked_n = '0; name_len_n = '0; extra_len_n = '0; rem_n = '0;
            dstart_n = '0; ns_n = '0;
          end
        end
      end
    end
    if (!ovf_n && pos_n < POSITION_BITS'(4)) fstat = ST_SHORT;
    else if (max_archive_bytes != 32'd0 &&
             (ovf_n || {{32{1'b0}}, pos_n} > {{POSITION_BITS{1'b0}}, max_archive_bytes}))
      fstat = ST_TOO_BIG;
    else if (err_n != ST_OK) fstat = err_n;
    else if (phase_n == PH_HDR && hidx_n != 5'd0) fstat = ST_TRAILER;
    else if (phase_n == PH_NAME || phase_n == PH_EXTRA || phase_n == PH_DATA) fstat = ST_TRUNC;
    else if (seen_n == '0) fstat = ST_NONE;
    else fstat = ST_OK;
    rb.valid = end_of_archive;
    rb.kind = 1'b1;
    rb.status = fstat;
    rb.index = 16'(seen_n);
    rb.last = 1'b1;
    res_a = rec ? ra : rb;
    res_b = rec ? rb : '0;
    if (!step) begin
      res_a = '0; res_b = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && end_of_archive)) begin
      phase <= PH_HDR; hidx <= '0; sig <= '0; comp <= '0; packed_size <= '0;
      unpacked_size <= '0; name_len <= '0; extra_len <= '0; rem <= '0;
      pos <= '0; dstart <= '0; seen <= '0; ovf <= 1'b0; ns <= '0; err <= ST_OK;
    end else if (step) begin
      phase <= phase_n; hidx <= hidx_n; sig <= sig_n; comp <= comp_n;
      packed_size <= packed_n; unpacked_size <= unpacked_n; name_len <= name_len_n;
      extra_len <= extra_len_n; rem <= rem_n; pos <= pos_n; dstart <= dstart_n;
      seen <= seen_n; ovf <= ovf_n; ns <= ns_n; err <= err_n;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/zip_stored_entry_walker.sv =====
// zip_stored_entry_walker: top level of the stored-entry ZIP walker
// depends on zsew_pkg, zsew_stream_if, zsew_walker, zsew_out_buf
//
//  channel   dir  payload                                             handshake
//  in_ch     in   has_byte, archive_byte, end_of_archive              valid/ready
//  out_ch    out  result_kind, status, entry_index, data_offset,      valid/ready
//                 entry_size, last_of_run
//  cfg_ch    in   index (2b), data (32b)                              valid/ready
//
// one input item per cycle while input ready is high; the walker updates its state in the cycle of
// acceptance and pushes up to two results into a four-slot output queue
// input ready drops only while the queue has fewer than two free slots
// rst is synchronous and clears walk state, limits and the queue
`default_nettype none
module zip_stored_entry_walker import zsew_pkg::*; #(
  parameter int POSITION_BITS = POSITION_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input wire logic      clk,
  input wire logic      rst,
  zsew_stream_if.sink   in_ch,
  zsew_stream_if.source out_ch,
  zsew_stream_if.sink   cfg_ch
);
  logic [31:0] max_archive_bytes, max_entry_bytes;
  logic [15:0] max_entry_count;
  logic room, step;
  result_t res_a, res_b;

  // limits must only change while idle (the user's duty; the block does not enforce it); writes are always taken
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      max_archive_bytes <= '0;
      max_entry_bytes <= '0;
      max_entry_count <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.payload.index)
        CFG_MAX_ARCHIVE: max_archive_bytes <= cfg_ch.payload.data;
        CFG_MAX_ENTRY: max_entry_bytes <= cfg_ch.payload.data;
        CFG_MAX_COUNT: max_entry_count <= cfg_ch.payload.data[15:0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready = room;
  assign step = in_ch.valid && room;

  zsew_walker #(.POSITION_BITS(POSITION_BITS), .COUNT_BITS(COUNT_BITS)) u_walk (
    .clk(clk), .rst(rst), .step(step),
    .has_byte(in_ch.payload.has_byte),
    .archive_byte(in_ch.payload.archive_byte),
    .end_of_archive(in_ch.payload.end_of_archive),
    .max_archive_bytes(max_archive_bytes),
    .max_entry_bytes(max_entry_bytes),
    .max_entry_count(max_entry_count),
    .res_a(res_a), .res_b(res_b)
  );

  zsew_out_buf u_buf (
    .clk(clk), .rst(rst), .push_a(res_a), .push_b(res_b), .room(room), .out(out_ch)
  );
endmodule
`default_nettype wire

// ===== rtl/zsew_checker.sv =====
// zsew_checker: port-level assertions for the walker, bound to the top level
// depends on zip_stored_entry_walker, the bind target
`default_nettype none
module zsew_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_kind,
  input wire logic [3:0] out_status,
  input wire logic out_last,
  input wire logic cfg_ready
);
  a_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_rec_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_kind |-> out_status == 4'd0) else $error("record status");
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind |-> out_last) else $error("status not last");
  a_cfg: assert property (@(posedge clk) disable iff (rst)
    cfg_ready) else $error("cfg stalled");
  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid && !in_valid |=> in_ready) else $error("ready stuck");
endmodule

bind zip_stored_entry_walker zsew_checker u_chk (
  .clk(clk), .rst(rst),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_kind(out_ch.payload.result_kind), .out_status(out_ch.payload.status),
  .out_last(out_ch.payload.last_of_run), .cfg_ready(cfg_ch.ready)
);
`default_nettype wire
